/* rtl/core/ellipsoid_vertex_generator_defines.svh */
// Assertion macros for the ellipsoid vertex generator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ELLIPSOID_VERTEX_GENERATOR_DEFINES_SVH
`define ELLIPSOID_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define EVG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/evg_pkg.sv */
// Shared constants, types and coefficient tables for the ellipsoid vertex generator.
// No dependencies.
package evg_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int PHASE_W = 16;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

    // sine polynomial, Q28, Horner order
    localparam int HORNER_STEPS = 4;
    localparam int SINE_LAT     = HORNER_STEPS + 2;
    localparam int COEF_W       = 29;
    localparam logic [COEF_W-1:0] HORNER_COEF [HORNER_STEPS+1] = '{
        29'd43068, 29'd1256749, 29'd21392326, 29'd173399667, 29'd421657428
    };

    localparam int NQ_W          = 31;
    localparam int SQ_W          = 64;
    localparam int ROOT_W        = 32;
    localparam int ISQRT_STAGES  = 16;
    localparam int QUOT_W        = 15;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = (QUOT_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int DVD_W         = NQ_W + 14;

    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_W      = 104;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THETA_ANGLES,
        REG_PHI_ANGLES,
        REG_RADIUS_X,
        REG_RADIUS_Y,
        REG_RADIUS_Z,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z
    } cfg_reg_t;

endpackage

/* rtl/core/evg_delay.sv */
// Stallable shift line that keeps side data aligned with the pipeline.
// No package dependencies.
module evg_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

/* rtl/core/evg_sine.sv */
// Pipelined Q1.14 sine of a 16-bit turn phase, one Horner step per stage.
// Depends on evg_pkg.
module evg_sine (
    input  logic                         clk,
    input  logic                         en,
    input  logic [evg_pkg::PHASE_W-1:0]  phase,
    output logic signed [15:0]           sine
);

    localparam int STEPS = evg_pkg::HORNER_STEPS;
    localparam int CW    = evg_pkg::COEF_W;
    localparam int RW    = CW + 2;

    logic [1:0]    quad_reg [STEPS+1];
    logic [14:0]   x_reg    [STEPS+1];
    logic [14:0]   z_reg    [STEPS];
    logic [CW-1:0] t_reg    [STEPS];
    logic signed [15:0] sine_reg;

    // fold to first quadrant, square
    logic [13:0] frac;
    logic [14:0] x0;
    logic [29:0] xx;

    assign frac = phase[13:0];
    assign x0   = phase[14] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
    assign xx   = x0 * x0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= phase[15:14];
            x_reg[0]    <= x0;
            z_reg[0]    <= xx[28:14];
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_horner
        logic [CW-1:0]  t_in;
        logic [CW+14:0] prod;
        logic [CW:0]    diff;

        if (k == 1)
        begin : g_first
            assign t_in = evg_pkg::HORNER_COEF[0];
        end
        else
        begin : g_rest
            assign t_in = t_reg[k-2];
        end

        assign prod = t_in * z_reg[k-1];
        assign diff = {1'b0, evg_pkg::HORNER_COEF[k]} - prod[CW+14:14];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[k-1]  <= diff[CW-1:0];
                x_reg[k]    <= x_reg[k-1];
                quad_reg[k] <= quad_reg[k-1];
            end
        end

        if (k < STEPS)
        begin : g_zpass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[k] <= z_reg[k-1];
                end
            end
        end
    end

    // final scale, round, cap, sign
    logic [CW+14:0] sx;
    logic [RW-1:0]  rnd;
    logic [16:0]    mag_full;
    logic [14:0]    mag;

    assign sx       = t_reg[STEPS-1] * x_reg[STEPS];
    assign rnd      = {1'b0, sx[CW+14:14]} + RW'(8192);
    assign mag_full = rnd[RW-1:14];
    assign mag      = (mag_full > 17'd16384) ? 15'd16384 : mag_full[14:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= quad_reg[STEPS][1] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
        end
    end

    assign sine = sine_reg;

endmodule

/* rtl/core/evg_isqrt.sv */
// Pipelined integer square root of a 64-bit value, two result bits per stage.
// Depends on evg_pkg.
module evg_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [evg_pkg::SQ_W-1:0]      val,
    output logic [evg_pkg::ROOT_W-1:0]    root
);

    localparam int NST = evg_pkg::ISQRT_STAGES;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } sqrt_acc_t;

    function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, int i);
        logic [63:0] bitv;
        logic [63:0] trial;
        sqrt_acc_t   r;
        bitv  = 64'd1 << (62 - 2 * i);
        trial = a.res + bitv;
        if (a.v >= trial)
        begin
            r.v   = a.v - trial;
            r.res = (a.res >> 1) + bitv;
        end
        else
        begin
            r.v   = a.v;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

    sqrt_acc_t acc_reg [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        sqrt_acc_t acc_in;
        sqrt_acc_t acc_mid;
        sqrt_acc_t acc_out;

        if (s == 0)
        begin : g_first
            assign acc_in.v   = val;
            assign acc_in.res = '0;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[s-1];
        end

        assign acc_mid = sqrt_step(acc_in, 2 * s);
        assign acc_out = sqrt_step(acc_mid, 2 * s + 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s] <= acc_out;
            end
        end
    end

    assign root = acc_reg[NST-1].res[evg_pkg::ROOT_W-1:0];

endmodule

/* rtl/core/evg_div.sv */
// Pipelined restoring divider for one normal component, two quotient bits per stage.
// Depends on evg_pkg.
module evg_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [evg_pkg::DVD_W-1:0]      dividend,
    input  logic [evg_pkg::ROOT_W-1:0]     divisor,
    output logic [evg_pkg::QUOT_W-1:0]     quot
);

    localparam int QW  = evg_pkg::QUOT_W;
    localparam int DW  = evg_pkg::DVD_W;
    localparam int RTW = evg_pkg::ROOT_W;
    localparam int PER = evg_pkg::DIV_PER_STAGE;
    localparam int NST = evg_pkg::DIV_STAGES;

    typedef struct packed {
        logic [RTW-1:0] rem;
        logic [QW-1:0]  q;
        logic [QW-1:0]  lo;
        logic [RTW-1:0] dsr;
    } div_acc_t;

    function automatic div_acc_t div_step(div_acc_t a, int i);
        logic [RTW:0] rem2;
        div_acc_t     r;
        r    = a;
        rem2 = {a.rem, a.lo[i]};
        if (rem2 >= {1'b0, a.dsr})
        begin
            rem2   = rem2 - {1'b0, a.dsr};
            r.q[i] = 1'b1;
        end
        r.rem = rem2[RTW-1:0];
        return r;
    endfunction

    div_acc_t acc_reg [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        div_acc_t acc_in;
        div_acc_t acc_out;

        if (s == 0)
        begin : g_first
            assign acc_in.rem = RTW'(dividend[DW-1:QW]);
            assign acc_in.q   = '0;
            assign acc_in.lo  = dividend[QW-1:0];
            assign acc_in.dsr = divisor;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[s-1];
        end

        always_comb
        begin
            acc_out = acc_in;
            for (int j = 0; j < PER; j++)
            begin
                if (QW - 1 - s * PER - j >= 0)
                begin
                    acc_out = div_step(acc_out, QW - 1 - s * PER - j);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s] <= acc_out;
            end
        end
    end

    assign quot = acc_reg[NST-1].q;

endmodule

/* rtl/core/ellipsoid_vertex_generator.sv */
// One beat is accepted per cycle while the pipeline enable is high.
// Throughput is set by the single pipeline enable: all stages move together and
// hold while m_tvalid is high and m_tready is low.
// Reset (rst_n low, asynchronous) clears all stage valid bits and loads the
// register defaults; payload registers are not reset.
`include "ellipsoid_vertex_generator_defines.svh"

module ellipsoid_vertex_generator #(
    parameter int  INDEX_BITS = evg_pkg::INDEX_BITS_DEF,
    parameter int  ANGLE_BITS = evg_pkg::ANGLE_BITS_DEF,
    localparam int IN_W       = ((2 * INDEX_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [evg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [evg_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // theta_index, phi_index
    input  logic [IN_W-1:0]                  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z
    output logic [evg_pkg::OUT_W-1:0]        m_tdata
);

    localparam int PW      = evg_pkg::PHASE_W;
    localparam int SUM_W   = (INDEX_BITS + 17 > ANGLE_BITS) ? INDEX_BITS + 17 : ANGLE_BITS;
    localparam int LAT     = 1 + evg_pkg::SINE_LAT + 5 + evg_pkg::ISQRT_STAGES + 1
                             + evg_pkg::DIV_STAGES + 1;
    localparam int MAG_DLY = 2 + evg_pkg::ISQRT_STAGES;
    localparam int VTX_DLY = MAG_DLY + 1 + evg_pkg::DIV_STAGES;
    localparam int NQ_W    = evg_pkg::NQ_W;
    localparam int QW      = evg_pkg::QUOT_W;
    localparam int DW      = evg_pkg::DVD_W;
    localparam int RTW     = evg_pkg::ROOT_W;
    localparam int OUT_PAD = evg_pkg::OUT_W - 102;

    // configuration registers
    logic [31:0]        theta_angles_reg;
    logic [31:0]        phi_angles_reg;
    logic [15:0]        radius_x_reg;
    logic [15:0]        radius_y_reg;
    logic [15:0]        radius_z_reg;
    logic signed [15:0] center_x_reg;
    logic signed [15:0] center_y_reg;
    logic signed [15:0] center_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_angles_reg <= 32'd8192;
            phi_angles_reg   <= 32'd4681;
            radius_x_reg     <= 16'd128;
            radius_y_reg     <= 16'd128;
            radius_z_reg     <= 16'd128;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (evg_pkg::cfg_reg_t'(cfg_addr))
                evg_pkg::REG_THETA_ANGLES: theta_angles_reg <= cfg_wdata;
                evg_pkg::REG_PHI_ANGLES:   phi_angles_reg   <= cfg_wdata;
                evg_pkg::REG_RADIUS_X:     radius_x_reg     <= cfg_wdata[15:0];
                evg_pkg::REG_RADIUS_Y:     radius_y_reg     <= cfg_wdata[15:0];
                evg_pkg::REG_RADIUS_Z:     radius_z_reg     <= cfg_wdata[15:0];
                evg_pkg::REG_CENTER_X:     center_x_reg     <= cfg_wdata[15:0];
                evg_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_wdata[15:0];
                evg_pkg::REG_CENTER_Z:     center_z_reg     <= cfg_wdata[15:0];
            endcase
        end
    end

    // pipeline control
    logic           pipe_en;
    logic [LAT-1:0] vld_reg;

    assign pipe_en  = !vld_reg[LAT-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // stage A: angles
    logic [INDEX_BITS-1:0] t_idx;
    logic [INDEX_BITS-1:0] p_idx;
    logic [SUM_W-1:0]      th_sum;
    logic [SUM_W-1:0]      ph_sum;
    logic [ANGLE_BITS-1:0] th_ang;
    logic [ANGLE_BITS-1:0] ph_ang;
    logic [PW-1:0]         th_phase;
    logic [PW-1:0]         ph_phase;
    logic [PW-1:0]         th_phase_reg;
    logic [PW-1:0]         ph_phase_reg;

    assign t_idx  = s_tdata[INDEX_BITS-1:0];
    assign p_idx  = s_tdata[2*INDEX_BITS-1:INDEX_BITS];
    assign th_sum = SUM_W'(theta_angles_reg[31:16])
                    + SUM_W'(t_idx) * SUM_W'(theta_angles_reg[15:0]);
    assign ph_sum = SUM_W'(phi_angles_reg[31:16])
                    + SUM_W'(p_idx) * SUM_W'(phi_angles_reg[15:0]);
    assign th_ang = th_sum[ANGLE_BITS-1:0];
    assign ph_ang = ph_sum[ANGLE_BITS-1:0];

    if (ANGLE_BITS >= PW)
    begin : g_phase_down
        assign th_phase = th_ang[ANGLE_BITS-1 -: PW];
        assign ph_phase = ph_ang[ANGLE_BITS-1 -: PW];
    end
    else
    begin : g_phase_up
        assign th_phase = {th_ang, {(PW-ANGLE_BITS){1'b0}}};
        assign ph_phase = {ph_ang, {(PW-ANGLE_BITS){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            th_phase_reg <= th_phase;
            ph_phase_reg <= ph_phase;
        end
    end

    // sine / cosine lanes
    logic signed [15:0] sin_t;
    logic signed [15:0] cos_t;
    logic signed [15:0] sin_p;
    logic signed [15:0] cos_p;
    logic [PW-1:0]      th_cphase;
    logic [PW-1:0]      ph_cphase;

    assign th_cphase = th_phase_reg + evg_pkg::QUARTER_TURN;
    assign ph_cphase = ph_phase_reg + evg_pkg::QUARTER_TURN;

    evg_sine u_sin_t (.clk(clk), .en(pipe_en), .phase(th_phase_reg), .sine(sin_t));
    evg_sine u_cos_t (.clk(clk), .en(pipe_en), .phase(th_cphase),    .sine(cos_t));
    evg_sine u_sin_p (.clk(clk), .en(pipe_en), .phase(ph_phase_reg), .sine(sin_p));
    evg_sine u_cos_p (.clk(clk), .en(pipe_en), .phase(ph_cphase),    .sine(cos_p));

    // stage P: trig products
    logic signed [31:0] prod_x_full;
    logic signed [31:0] prod_y_full;
    logic signed [29:0] prod_x_reg;
    logic signed [29:0] prod_y_reg;
    logic signed [15:0] cp_reg;

    assign prod_x_full = sin_p * cos_t;
    assign prod_y_full = sin_p * sin_t;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            prod_x_reg <= prod_x_full[29:0];
            prod_y_reg <= prod_y_full[29:0];
            cp_reg     <= cos_p;
        end
    end

    // stage O: offsets, 28 fraction bits
    logic signed [46:0] off_x_full;
    logic signed [46:0] off_y_full;
    logic signed [32:0] off_z_full;
    logic signed [45:0] off_reg [3];

    assign off_x_full = $signed({1'b0, radius_x_reg}) * prod_x_reg;
    assign off_y_full = $signed({1'b0, radius_y_reg}) * prod_y_reg;
    assign off_z_full = $signed({1'b0, radius_z_reg}) * cp_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            off_reg[0] <= off_x_full[45:0];
            off_reg[1] <= off_y_full[45:0];
            off_reg[2] <= {off_z_full[31:0], 14'd0};
        end
    end

    // stage V: vertex and rounded offset; stage Q: squares
    logic signed [15:0] cen [3];
    logic signed [17:0] vtx_reg [3];
    logic               neg_reg [3];
    logic [NQ_W-1:0]    nq_reg  [3];
    logic [2*NQ_W-1:0]  sq_reg  [3];

    assign cen[0] = center_x_reg;
    assign cen[1] = center_y_reg;
    assign cen[2] = center_z_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic               neg;
        logic [44:0]        mag;
        logic [44:0]        mag_r28;
        logic [44:0]        mag_r14;
        logic signed [19:0] r28_s;
        logic signed [19:0] vsum;
        logic signed [17:0] vsat;

        assign neg     = off_reg[i][45];
        assign mag     = neg ? 45'(-off_reg[i]) : off_reg[i][44:0];
        assign mag_r28 = mag + 45'd134217728;
        assign mag_r14 = mag + 45'd8192;
        assign r28_s   = $signed({3'b000, mag_r28[44:28]});
        assign vsum    = 20'(cen[i]) + (neg ? -r28_s : r28_s);

        always_comb
        begin
            priority if (vsum > 20'sd131071)
            begin
                vsat = 18'sh1FFFF;
            end
            else if (vsum < -20'sd131072)
            begin
                vsat = 18'sh20000;
            end
            else
            begin
                vsat = vsum[17:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                vtx_reg[i] <= vsat;
                neg_reg[i] <= neg;
                nq_reg[i]  <= mag_r14[44:14];
                sq_reg[i]  <= nq_reg[i] * nq_reg[i];
            end
        end
    end

    // stage S: sum of squares
    logic [evg_pkg::SQ_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sum_reg <= evg_pkg::SQ_W'(sq_reg[0]) + evg_pkg::SQ_W'(sq_reg[1])
                       + evg_pkg::SQ_W'(sq_reg[2]);
        end
    end

    logic [RTW-1:0] root;

    evg_isqrt u_isqrt (.clk(clk), .en(pipe_en), .val(sum_reg), .root(root));

    // side lines
    logic [3*NQ_W-1:0] mag_dly;
    logic [56:0]       vtx_dly;

    evg_delay #(.WIDTH(3 * NQ_W), .DEPTH(MAG_DLY)) u_mag_dly (
        .clk (clk),
        .en  (pipe_en),
        .din ({nq_reg[2], nq_reg[1], nq_reg[0]}),
        .dout(mag_dly)
    );

    evg_delay #(.WIDTH(57), .DEPTH(VTX_DLY)) u_vtx_dly (
        .clk (clk),
        .en  (pipe_en),
        .din ({neg_reg[2], neg_reg[1], neg_reg[0], vtx_reg[2], vtx_reg[1], vtx_reg[0]}),
        .dout(vtx_dly)
    );

    // stage R: divider operands
    logic [RTW-1:0] norm;
    logic [RTW-1:0] dsr_reg;
    logic [DW-1:0]  dvd_reg [3];
    logic [QW-1:0]  quot [3];

    assign norm = (root == '0) ? RTW'(1) : root;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dsr_reg <= norm;
            for (int i = 0; i < 3; i++)
            begin
                dvd_reg[i] <= {mag_dly[i*NQ_W +: NQ_W], 14'd0} + DW'(norm >> 1);
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        evg_div u_div (
            .clk     (clk),
            .en      (pipe_en),
            .dividend(dvd_reg[i]),
            .divisor (dsr_reg),
            .quot    (quot[i])
        );
    end

    // output register
    logic [15:0] nrm [3];
    logic [evg_pkg::OUT_W-1:0] m_tdata_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign nrm[i] = vtx_dly[54+i] ? (16'd0 - {1'b0, quot[i]}) : {1'b0, quot[i]};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m_tdata_reg <= {{OUT_PAD{1'b0}}, nrm[2], nrm[1], nrm[0], vtx_dly[53:0]};
        end
    end

    assign m_tdata = m_tdata_reg;

    `EVG_ASSERT_IMPLY(a_normal_x_range, clk, rst_n, m_tvalid, ($signed(m_tdata[69:54]) <= 16'sd16384) && ($signed(m_tdata[69:54]) >= -16'sd16384), "normal_x out of range")
    `EVG_ASSERT_NEXT(a_stall_holds_valid, clk, rst_n, !pipe_en, $stable(vld_reg), "valid bits moved during stall")
    `EVG_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_tvalid && s_tready, vld_reg[0], "accepted beat not in first stage")

endmodule
